// ===== hdl/chts_pkg.sv =====
// Shared types for the cubic Hermite curve tessellator.
// No dependencies; imported by cubic_hermite_curve_tessellator_unit.
package chts_pkg;

  // what a token in the evaluation pipeline does at the output stage
  typedef enum logic {
    TOK_SAMPLE,
    TOK_LOAD
  } tok_kind_t;

  // selects one of the four Hermite basis functions
  typedef enum logic [1:0] {
    BASIS_H1,
    BASIS_H2,
    BASIS_H3,
    BASIS_H4
  } basis_sel_t;

endpackage

// ===== hdl/cubic_hermite_curve_tessellator_unit.sv =====
// Cubic Hermite curve tessellator: control points in, line segments out.
// Depends on chts_pkg (token and basis select types).
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | new_curve, point_x, point_y, tangent_x/_y
//  out     | out_valid/ out_ready | start_x, start_y, end_x, end_y, last
//
// A curve-start point yields no line; any other point yields SAMPLES lines, one per
// cycle while the output is not stalled, from the sample counter in the input stage.
// The next point is taken in the cycle the current segment issues its last sample,
// so a stream of points runs with no gap between segments.
// The first line passes from the input register through the product register
// (weight ROM + multiply) into the output register (sum + round + saturate).
// rst is synchronous and clears all valids and the held control points.
// A stalled output freezes the whole pipeline; an idle input stage still takes a point.
module cubic_hermite_curve_tessellator_unit #(
  parameter int SAMPLES          = 50,
  parameter int COORD_BITS       = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         new_curve,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] tangent_x,
  input  logic signed [COORD_BITS-1:0] tangent_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] start_x,
  output logic signed [COORD_BITS-1:0] start_y,
  output logic signed [COORD_BITS-1:0] end_x,
  output logic signed [COORD_BITS-1:0] end_y,
  output logic                         last
);
  import chts_pkg::*;

  localparam int KW  = (SAMPLES > 2) ? $clog2(SAMPLES) : 1;
  localparam int WW  = WEIGHT_FRAC_BITS + 2;
  localparam int PW  = WW + COORD_BITS;
  localparam int SW  = PW + 3;
  localparam int QW  = SW - WEIGHT_FRAC_BITS;
  localparam longint DEN  = longint'(SAMPLES) * SAMPLES * SAMPLES;
  localparam longint ONE  = longint'(1) <<< WEIGHT_FRAC_BITS;
  localparam longint CMAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam logic [KW-1:0]          K_LAST = KW'(SAMPLES - 1);
  localparam logic signed [WW-1:0]   W_ONE  = WW'(ONE);
  localparam logic signed [SW-1:0]   HALF   = SW'(longint'(1) <<< (WEIGHT_FRAC_BITS - 1));
  localparam logic signed [QW-1:0]   QMAX   = QW'(CMAX);
  localparam logic signed [QW-1:0]   QMIN   = QW'(-CMAX - 1);

  typedef logic [SAMPLES-1:0][WW-1:0] wtab_t;

  // basis weight for numerator over SAMPLES^3, rounded half away from zero
  function automatic logic [WW-1:0] calc_weight(input longint num);
    longint q;
    if (num >= 0) begin
      q = (num * ONE + DEN / 2) / DEN;
    end else begin
      q = -((-num * ONE + DEN / 2) / DEN);
    end
    return WW'(q);
  endfunction

  // weight table for one basis function over k = 0..SAMPLES-1
  function automatic wtab_t build_tab(input basis_sel_t sel);
    wtab_t  tab;
    longint n;
    longint k;
    longint num;
    n = SAMPLES;
    for (int i = 0; i < SAMPLES; i++) begin
      k = i;
      unique case (sel)
        BASIS_H1: num = 2 * k * k * k - 3 * k * k * n + n * n * n;
        BASIS_H2: num = -2 * k * k * k + 3 * k * k * n;
        BASIS_H3: num = k * k * k - 2 * k * k * n + k * n * n;
        BASIS_H4: num = k * k * k - k * k * n;
        default:  num = 0;
      endcase
      tab[i] = calc_weight(num);
    end
    return tab;
  endfunction

  localparam wtab_t H1_TAB = build_tab(BASIS_H1);
  localparam wtab_t H2_TAB = build_tab(BASIS_H2);
  localparam wtab_t H3_TAB = build_tab(BASIS_H3);
  localparam wtab_t H4_TAB = build_tab(BASIS_H4);

  // drop fraction bits of a sum that already holds the rounding half, clamp to coordinate range
  function automatic logic signed [COORD_BITS-1:0] round_sat(input logic signed [SW-1:0] acc);
    logic signed [QW-1:0] q;
    q = acc[SW-1:WEIGHT_FRAC_BITS];
    if (q > QMAX) begin
      q = QMAX;
    end else if (q < QMIN) begin
      q = QMIN;
    end
    return q[COORD_BITS-1:0];
  endfunction

  // input stage: segment endpoints and sample counter
  logic                         have_point;
  logic                         gen_valid;
  tok_kind_t                    gen_kind;
  logic [KW-1:0]                step_index;
  logic signed [COORD_BITS-1:0] p0x, p0y, t0x, t0y;
  logic signed [COORD_BITS-1:0] p1x, p1y, t1x, t1y;

  // product stage
  logic                         s1_valid;
  tok_kind_t                    s1_kind;
  logic                         s1_last;
  logic signed [PW-1:0]         prod_x [4];
  logic signed [PW-1:0]         prod_y [4];

  // last emitted sample, start of the next line
  logic signed [COORD_BITS-1:0] sample_x, sample_y;

  logic                         advance;
  logic                         gen_done;
  logic                         in_xfer;
  logic                         gen_last;
  logic signed [WW-1:0]         w1, w2, w3, w4;
  logic signed [SW-1:0]         acc_x, acc_y;
  logic signed [COORD_BITS-1:0] res_x, res_y;

  // pipeline moves whenever the output register is free or drained
  assign advance  = !out_valid || out_ready;
  assign gen_last = (step_index == K_LAST);
  assign gen_done = (gen_kind == TOK_LOAD) || gen_last;
  assign in_ready = !gen_valid || (advance && gen_done);
  assign in_xfer  = in_valid && in_ready;

  // input register and sample counter
  always_ff @(posedge clk) begin
    if (rst) begin
      have_point <= 1'b0;
      gen_valid  <= 1'b0;
      gen_kind   <= TOK_LOAD;
      step_index <= '0;
    end else if (in_xfer) begin
      have_point <= 1'b1;
      gen_valid  <= 1'b1;
      gen_kind   <= (new_curve || !have_point) ? TOK_LOAD : TOK_SAMPLE;
      step_index <= '0;
    end else if (gen_valid && advance) begin
      if (gen_done) begin
        gen_valid  <= 1'b0;
        step_index <= '0;
      end else begin
        step_index <= step_index + KW'(1);
      end
    end
  end

  // new point becomes segment end; old end becomes segment start
  always_ff @(posedge clk) begin
    if (rst) begin
      p0x <= '0;
      p0y <= '0;
      t0x <= '0;
      t0y <= '0;
      p1x <= '0;
      p1y <= '0;
      t1x <= '0;
      t1y <= '0;
    end else if (in_xfer) begin
      p0x <= p1x;
      p0y <= p1y;
      t0x <= t1x;
      t0y <= t1y;
      p1x <= point_x;
      p1y <= point_y;
      t1x <= tangent_x;
      t1y <= tangent_y;
    end
  end

  // basis weights; a load token passes the new point through unchanged
  always_comb begin
    if (gen_kind == TOK_LOAD) begin
      w1 = '0;
      w2 = W_ONE;
      w3 = '0;
      w4 = '0;
    end else begin
      w1 = $signed(H1_TAB[step_index]);
      w2 = $signed(H2_TAB[step_index]);
      w3 = $signed(H3_TAB[step_index]);
      w4 = $signed(H4_TAB[step_index]);
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= gen_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_kind   <= gen_kind;
      s1_last   <= gen_last;
      prod_x[0] <= w1 * p0x;
      prod_x[1] <= w2 * p1x;
      prod_x[2] <= w3 * t0x;
      prod_x[3] <= w4 * t1x;
      prod_y[0] <= w1 * p0y;
      prod_y[1] <= w2 * p1y;
      prod_y[2] <= w3 * t0y;
      prod_y[3] <= w4 * t1y;
    end
  end

  // sum of products, round and saturate
  always_comb begin
    acc_x = SW'(prod_x[0]) + SW'(prod_x[1]) + SW'(prod_x[2]) + SW'(prod_x[3]) + HALF;
    acc_y = SW'(prod_y[0]) + SW'(prod_y[1]) + SW'(prod_y[2]) + SW'(prod_y[3]) + HALF;
    res_x = round_sat(acc_x);
    res_y = round_sat(acc_y);
  end

  // output register and running sample
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sample_x  <= '0;
      sample_y  <= '0;
    end else if (advance) begin
      out_valid <= s1_valid && (s1_kind == TOK_SAMPLE);
      if (s1_valid) begin
        sample_x <= res_x;
        sample_y <= res_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && (s1_kind == TOK_SAMPLE)) begin
      start_x <= sample_x;
      start_y <= sample_y;
      end_x   <= res_x;
      end_y   <= res_y;
      last    <= s1_last;
    end
  end

endmodule

// ===== test/cubic_hermite_curve_tessellator_checker.sv =====
// Line checker for the cubic Hermite curve tessellator: watches both channels,
// predicts every line from the accepted control points and compares in order.
// No package dependencies; instantiated by tb_cubic_hermite_curve_tessellator_unit.
module cubic_hermite_curve_tessellator_checker #(
  parameter int SAMPLES          = 50,
  parameter int COORD_BITS       = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         new_curve,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] tangent_x,
  input  logic signed [COORD_BITS-1:0] tangent_y,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic                         last,
  output int                           mismatches,
  output int                           lines_pending,
  output int                           lines_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   last;
  } line_t;

  localparam longint CUBE      = longint'(SAMPLES) * SAMPLES * SAMPLES;
  localparam longint UNITY     = longint'(1) << WEIGHT_FRAC_BITS;
  localparam longint HALF      = UNITY / 2;
  localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  // segment state: held control point and the end of the last line
  logic   have_point;
  coord_t held_px, held_py, held_tx, held_ty;
  coord_t trace_x, trace_y;
  line_t  lines_q[$];

  // basis numerator over N^3 scaled to fixed point, ties away from zero
  function automatic longint basis_weight(longint num);
    if (num >= 0) return (num * UNITY + CUBE / 2) / CUBE;
    return -((-num * UNITY + CUBE / 2) / CUBE);
  endfunction

  // floor of sum plus half, then clamp to the coordinate range
  function automatic coord_t round_saturate(longint acc);
    longint q;
    q = (acc + HALF) >>> WEIGHT_FRAC_BITS;
    if (q > COORD_MAX) q = COORD_MAX;
    else if (q < COORD_MIN) q = COORD_MIN;
    return coord_t'(q);
  endfunction

  // expected lines for one accepted control point
  task automatic tessellate_point(input logic nc, input coord_t px, input coord_t py,
                                  input coord_t tx, input coord_t ty);
    if (nc || !have_point) begin
      trace_x = px;
      trace_y = py;
    end else begin
      for (int k = 0; k < SAMPLES; k++) begin
        longint n, kk, k2, k3, w1, w2, w3, w4;
        line_t  ln;
        n  = SAMPLES;
        kk = k;
        k2 = kk * kk;
        k3 = k2 * kk;
        w1 = basis_weight(2 * k3 - 3 * k2 * n + n * n * n);
        w2 = basis_weight(-2 * k3 + 3 * k2 * n);
        w3 = basis_weight(k3 - 2 * k2 * n + kk * n * n);
        w4 = basis_weight(k3 - k2 * n);
        ln.sx   = trace_x;
        ln.sy   = trace_y;
        ln.ex   = round_saturate(w1 * longint'(held_px) + w3 * longint'(held_tx) +
                                 w2 * longint'(px) + w4 * longint'(tx));
        ln.ey   = round_saturate(w1 * longint'(held_py) + w3 * longint'(held_ty) +
                                 w2 * longint'(py) + w4 * longint'(ty));
        ln.last = (k == SAMPLES - 1);
        lines_q.push_back(ln);
        trace_x = ln.ex;
        trace_y = ln.ey;
      end
    end
    held_px    = px;
    held_py    = py;
    held_tx    = tx;
    held_ty    = ty;
    have_point = 1'b1;
  endtask

  // compare one output transfer with the oldest expected line
  task automatic check_line();
    line_t want;
    if (lines_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: line with none expected: start (%0d,%0d) end (%0d,%0d) last %0b",
                 $realtime, start_x, start_y, end_x, end_y, last);
    end else begin
      want = lines_q.pop_front();
      lines_checked++;
      if (want.sx !== start_x || want.sy !== start_y || want.ex !== end_x ||
          want.ey !== end_y || want.last !== last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: bad line %0d: expected start (%0d,%0d) end (%0d,%0d) last %0b",
                   $realtime, lines_checked, want.sx, want.sy, want.ex, want.ey, want.last);
          $display("    got start (%0d,%0d) end (%0d,%0d) last %0b",
                   start_x, start_y, end_x, end_y, last);
        end
      end
    end
  endtask

  // sample both channels at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      have_point    = 1'b0;
      held_px       = '0;
      held_py       = '0;
      held_tx       = '0;
      held_ty       = '0;
      trace_x       = '0;
      trace_y       = '0;
      lines_q.delete();
      mismatches    = 0;
      lines_checked = 0;
    end else begin
      if (out_valid && out_ready) check_line();
      if (in_valid && in_ready)
        tessellate_point(new_curve, point_x, point_y, tangent_x, tangent_y);
    end
    lines_pending = lines_q.size();
  end

endmodule

// ===== test/tb_cubic_hermite_curve_tessellator_unit.sv =====
// Testbench top for cubic_hermite_curve_tessellator_unit: drives control points,
// toggles output backpressure and gives the verdict.
// Depends on the unit and on cubic_hermite_curve_tessellator_checker.
module tb_cubic_hermite_curve_tessellator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLES          = 50;
  localparam int COORD_BITS       = 16;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int RANDOM_POINTS    = 460;
  localparam int STALL_LIMIT      = 2000;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic   clk       = 1'b0;
  logic   rst       = 1'b1;
  logic   in_valid  = 1'b0;
  logic   in_ready;
  logic   new_curve = 1'b0;
  coord_t point_x   = '0;
  coord_t point_y   = '0;
  coord_t tangent_x = '0;
  coord_t tangent_y = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t start_x, start_y, end_x, end_y;
  logic   last;

  logic   calm = 1'b0;
  int     mismatches, lines_pending, lines_checked;
  int     points_sent  = 0;
  int     curve_starts = 0;
  int     quiet_cycles = 0;

  always #5 clk = ~clk;

  cubic_hermite_curve_tessellator_unit #(
    .SAMPLES(SAMPLES), .COORD_BITS(COORD_BITS), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .new_curve(new_curve),
    .point_x(point_x), .point_y(point_y), .tangent_x(tangent_x), .tangent_y(tangent_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y), .last(last)
  );

  cubic_hermite_curve_tessellator_checker #(
    .SAMPLES(SAMPLES), .COORD_BITS(COORD_BITS), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) line_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .new_curve(new_curve),
    .point_x(point_x), .point_y(point_y), .tangent_x(tangent_x), .tangent_y(tangent_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y), .last(last),
    .mismatches(mismatches), .lines_pending(lines_pending), .lines_checked(lines_checked)
  );

  // random output backpressure, none during the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 18);
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one control point transfer, with random idle cycles ahead of it
  task automatic send_point(input logic nc, input coord_t px, input coord_t py,
                            input coord_t tx, input coord_t ty);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    new_curve <= nc;
    point_x   <= px;
    point_y   <= py;
    tangent_x <= tx;
    tangent_y <= ty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    points_sent++;
    if (nc) curve_starts++;
  endtask

  // mix of full range, small, medium and extreme coordinates
  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'(int'($urandom_range(400)) - 200);
      2: return coord_t'(int'($urandom_range(8000)) - 4000);
      default: begin
        case ($urandom_range(3))
          0: return CMAX;
          1: return CMIN;
          2: return coord_t'(0);
          default: return coord_t'(-1);
        endcase
      end
    endcase
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: point with no previous point, then a plain segment
    send_point(1'b0, 100, -100, 50, 50);
    send_point(1'b0, 300, 200, 0, 0);
    // curve start, then saturating segments at the coordinate extremes
    send_point(1'b1, 0, 0, 0, 0);
    send_point(1'b0, CMAX, CMAX, CMAX, CMAX);
    send_point(1'b0, CMIN, CMIN, CMIN, CMIN);
    send_point(1'b0, 0, 0, CMAX, CMIN);
    send_point(1'b0, CMAX, CMIN, CMIN, CMAX);
    // curve start mid-stream, small values near rounding ties
    send_point(1'b1, CMIN, CMAX, 0, 0);
    send_point(1'b0, -1, -1, -1, -1);
    send_point(1'b0, 1, 1, 1, -1);
    // back-to-back curve starts
    send_point(1'b1, 1234, -4321, 0, 0);
    send_point(1'b1, 20, 20, 5, 5);
    send_point(1'b0, -20, 40, -300, 700);
    send_point(1'b0, 0, 0, 0, 0);

    // random curves with occasional restarts, one long stretch without idling
    for (int i = 0; i < RANDOM_POINTS; i++) begin
      calm <= (i >= 150 && i < 250);
      send_point($urandom_range(99) < 8, rand_coord(), rand_coord(),
                 rand_coord(), rand_coord());
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    // drain expected lines, then let the pipeline settle
    @(negedge clk);
    while (lines_pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d control points (%0d curve starts) and %0d checked lines,",
             points_sent, curve_starts, lines_checked);
    $display("including saturated samples and random output backpressure");
    if (mismatches == 0 && lines_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/chts_pkg.sv
hdl/cubic_hermite_curve_tessellator_unit.sv
test/cubic_hermite_curve_tessellator_checker.sv
test/tb_cubic_hermite_curve_tessellator_unit.sv
